// File: design/nbm_pkg.sv
// Shared types and constants for the NTT base-multiply accumulator.
// Used by nbm_lane, nbm_reduce and the top level; depends on nothing.
package nbm_pkg;

    localparam int unsigned X_W    = 14;   // first polynomial coefficient width
    localparam int unsigned Y_W    = 13;   // second polynomial coefficient width
    localparam int unsigned PROD_W = X_W + Y_W;
    localparam int unsigned TERM_W = PROD_W + 1;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned OUT_W  = 14;
    localparam int unsigned HALF_W = 16;   // Montgomery radix is 2^16

    localparam int unsigned S_DATA_W = 136;
    localparam int unsigned M_DATA_W = 56;

    // q^-1 mod 2^16 and the modulus itself
    localparam logic [HALF_W-1:0] MONT_QINV = 16'd62209;
    localparam logic signed [12:0] MONT_Q    = 13'sd3329;

    // Pipeline control seen by every lane
    typedef struct packed {
        logic adv;    // whole pipeline moves on this cycle
        logic acc;    // product stage holds a request to accumulate
        logic last;   // that request closes the run
    } t_lane_ctl;

endpackage

// File: design/nbm_lane.sv
// One accumulation lane: two products, combined by add or subtract, summed over a run.
// Depends on nbm_pkg for widths and the control struct.
module nbm_lane
    import nbm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctl               i_ctl,
    input  logic                    i_neg,
    input  logic signed [X_W-1:0]   i_a,
    input  logic signed [Y_W-1:0]   i_b,
    input  logic signed [X_W-1:0]   i_c,
    input  logic signed [Y_W-1:0]   i_d,
    output logic [SUM_W-1:0]        o_total
);

    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pc;
    logic                     r_neg;
    logic signed [TERM_W-1:0] n_term;
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         n_sum;
    logic [SUM_W-1:0]         r_total;

    // Product registers hold payload only.
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_pa  <= i_a * i_b;
            r_pc  <= i_c * i_d;
            r_neg <= i_neg;
        end
    end

    always_comb begin
        if (r_neg) begin
            n_term = TERM_W'(r_pa) - TERM_W'(r_pc);
        end else begin
            n_term = TERM_W'(r_pa) + TERM_W'(r_pc);
        end
        n_sum = r_sum + SUM_W'(n_term);
    end

    // The running sum wraps modulo 2^32 and clears once a run closes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.adv && i_ctl.acc) begin
            r_sum <= i_ctl.last ? '0 : n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv && i_ctl.acc && i_ctl.last) begin
            r_total <= n_sum;
        end
    end

    assign o_total = r_total;

endmodule

// File: design/nbm_reduce.sv
// Two-stage 16-bit Montgomery reduction (q = 3329) of one 32-bit sum.
// Depends on nbm_pkg for the constants.
module nbm_reduce
    import nbm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en_a,
    input  logic                    i_en_b,
    input  logic [SUM_W-1:0]        i_sum,
    output logic signed [OUT_W-1:0] o_res
);

    logic [HALF_W-1:0]        w_lo;
    logic signed [HALF_W-1:0] r_t;
    logic signed [SUM_W-1:0]  r_a;
    logic signed [28:0]       w_tq;
    logic signed [33:0]       w_diff;
    logic signed [OUT_W-1:0]  r_res;

    assign w_lo = HALF_W'(i_sum[HALF_W-1:0] * MONT_QINV);

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_t <= signed'(w_lo);
            r_a <= signed'(i_sum);
        end
    end

    // a - t*q is a multiple of 2^16, so the shift is exact.
    assign w_tq   = 29'(r_t) * 29'(MONT_Q);
    assign w_diff = 34'(r_a) - 34'(w_tq);

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_res <= w_diff[HALF_W+OUT_W-1:HALF_W];
        end
    end

    assign o_res = r_res;

endmodule

// File: design/ntt_basemul_accumulate_montgomery.sv
// Base-multiply accumulator for NTT-domain polynomial pairs with Montgomery output.
// Throughput: one request per cycle while the output register is free or being drained.
// The result appears on m_tvalid once the request marked last has passed the registered steps
// in order (products at the edge that takes it, then accumulate, Montgomery step one, step two).
// Reset (i_rst_n low, synchronous) clears the four running sums and all valid flags.
// Depends on nbm_pkg, nbm_lane and nbm_reduce.
module ntt_basemul_accumulate_montgomery
    import nbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // x_even0, x_odd0, x_even1, x_odd1 (14 b each), y_even0, y_odd0, y_even1,
    // y_odd1, y_zeta0, y_zeta1 (13 b each), two zero pad bits at the top
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,   // last_term
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_even0, out_odd0, out_even1, out_odd1 (14 b each)
    output logic [M_DATA_W-1:0] m_tdata
);

    // Field extraction from the packed input request.
    logic signed [X_W-1:0] w_xe0, w_xo0, w_xe1, w_xo1;
    logic signed [Y_W-1:0] w_ye0, w_yo0, w_ye1, w_yo1, w_yz0, w_yz1;

    assign w_xe0 = s_tdata[13:0];
    assign w_xo0 = s_tdata[27:14];
    assign w_xe1 = s_tdata[41:28];
    assign w_xo1 = s_tdata[55:42];
    assign w_ye0 = s_tdata[68:56];
    assign w_yo0 = s_tdata[81:69];
    assign w_ye1 = s_tdata[94:82];
    assign w_yo1 = s_tdata[107:95];
    assign w_yz0 = s_tdata[120:108];
    assign w_yz1 = s_tdata[133:121];

    // The whole pipeline moves together; it only halts when a finished result
    // sits in the output register and the downstream side is not taking it.
    logic      adv;
    logic      r_v1, r_l1, r_v2, r_v3, r_out_valid;
    t_lane_ctl w_ctl;

    assign adv      = !r_out_valid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = r_out_valid;

    assign w_ctl.adv  = adv;
    assign w_ctl.acc  = r_v1;
    assign w_ctl.last = r_l1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_l1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= s_tvalid;
            r_l1        <= s_tlast;
            r_v2        <= r_v1 && r_l1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    // Four lanes, one per running sum. Only the even sum of pair one subtracts
    // its zeta product.
    logic [SUM_W-1:0] w_tot_e0, w_tot_o0, w_tot_e1, w_tot_o1;

    nbm_lane u_lane_e0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_neg(1'b0),
        .i_a(w_xe0), .i_b(w_ye0), .i_c(w_xo0), .i_d(w_yz0), .o_total(w_tot_e0)
    );

    nbm_lane u_lane_o0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_neg(1'b0),
        .i_a(w_xe0), .i_b(w_yo0), .i_c(w_xo0), .i_d(w_ye0), .o_total(w_tot_o0)
    );

    nbm_lane u_lane_e1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_neg(1'b1),
        .i_a(w_xe1), .i_b(w_ye1), .i_c(w_xo1), .i_d(w_yz1), .o_total(w_tot_e1)
    );

    nbm_lane u_lane_o1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_neg(1'b0),
        .i_a(w_xe1), .i_b(w_yo1), .i_c(w_xo1), .i_d(w_ye1), .o_total(w_tot_o1)
    );

    // Merge stage: each closed sum is reduced and the four results are loaded
    // together into the output register.
    logic en_a, en_b;
    logic signed [OUT_W-1:0] w_re0, w_ro0, w_re1, w_ro1;

    assign en_a = adv && r_v2;
    assign en_b = adv && r_v3;

    nbm_reduce u_red_e0 (
        .i_clk(i_clk), .i_en_a(en_a), .i_en_b(en_b), .i_sum(w_tot_e0), .o_res(w_re0)
    );

    nbm_reduce u_red_o0 (
        .i_clk(i_clk), .i_en_a(en_a), .i_en_b(en_b), .i_sum(w_tot_o0), .o_res(w_ro0)
    );

    nbm_reduce u_red_e1 (
        .i_clk(i_clk), .i_en_a(en_a), .i_en_b(en_b), .i_sum(w_tot_e1), .o_res(w_re1)
    );

    nbm_reduce u_red_o1 (
        .i_clk(i_clk), .i_en_a(en_a), .i_en_b(en_b), .i_sum(w_tot_o1), .o_res(w_ro1)
    );

    assign m_tdata = {w_ro1, w_re1, w_ro0, w_re0};

    // A result can only appear after a reduction was in flight.
    a_out_from_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_v3))
        else $error("output valid without a reduction in flight");

    // A closed sum only follows a request that carried the last mark.
    a_total_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v2) |-> $past(r_v1 && r_l1))
        else $error("closed sum without a last request");

    // A stalled pipeline keeps its reduction stage occupied.
    a_reduce_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !adv) |=> r_v3)
        else $error("reduction stage lost during a stall");

endmodule
